@@ sv/crfe_pkg.sv @@
// ----------------------------------------------------------------------------
// crfe_pkg
// Shared types and constants of the clipped rectangle fill engine: register
// map, pixel formats, configuration bundle and result bundle.
// ----------------------------------------------------------------------------
package crfe_pkg;

  // default parameter values
  localparam int MaxDimDefault   = 4096;
  localparam int AddrBitsDefault = 32;

  // fixed field widths
  localparam int CoordW = 12;
  localparam int DimW   = 13;
  localparam int PitchW = 16;
  localparam int ColorW = 8;
  localparam int DataW  = 32;
  localparam int BeW    = 4;
  localparam int PaddrW = 5;

  // register map, word index into the configuration space
  typedef enum logic [2:0] {
    RegBase   = 3'd0,
    RegWidth  = 3'd1,
    RegHeight = 3'd2,
    RegPitch  = 3'd3,
    RegFormat = 3'd4
  } reg_idx_e;

  // pixel formats
  typedef enum logic [1:0] {
    FmtBgra32 = 2'd0,
    FmtBgr24  = 2'd1,
    FmtRgb565 = 2'd2,
    FmtOther  = 2'd3
  } pix_fmt_e;

  // input item op codes
  typedef enum logic {
    OpStart = 1'b0,
    OpStep  = 1'b1
  } op_e;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [31:0]       base_address;
    logic [DimW-1:0]   screen_width;
    logic [DimW-1:0]   screen_height;
    logic [PitchW-1:0] row_pitch;
    pix_fmt_e          pixel_format;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic              write_valid;
    logic [31:0]       write_address;
    logic [DataW-1:0]  write_data;
    logic [BeW-1:0]    byte_enables;
    logic [CoordW-1:0] pixel_col;
    logic [CoordW-1:0] pixel_row;
    logic              last_pixel;
  } res_t;

endpackage

@@ sv/crfe_regs.sv @@
// ----------------------------------------------------------------------------
// crfe_regs
// APB-style configuration register file: base address, screen size, row
// pitch and pixel format. Zero wait states, reads return register contents.
// ----------------------------------------------------------------------------
module crfe_regs import crfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[PaddrW-1:2]);
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        RegBase:   cfg_q.base_address  <= pwdata;
        RegWidth:  cfg_q.screen_width  <= pwdata[DimW-1:0];
        RegHeight: cfg_q.screen_height <= pwdata[DimW-1:0];
        RegPitch:  cfg_q.row_pitch     <= pwdata[PitchW-1:0];
        RegFormat: cfg_q.pixel_format  <= pix_fmt_e'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      RegBase:   prdata = cfg_q.base_address;
      RegWidth:  prdata = 32'(cfg_q.screen_width);
      RegHeight: prdata = 32'(cfg_q.screen_height);
      RegPitch:  prdata = 32'(cfg_q.row_pitch);
      RegFormat: prdata = 32'(cfg_q.pixel_format);
      default:   prdata = '0;
    endcase
  end

endmodule

@@ sv/crfe_core.sv @@
// ----------------------------------------------------------------------------
// crfe_core
// Fill datapath: input register, fill state (clip bounds, cursor, row
// address, packed colour) and result register with hold on stall.
// ----------------------------------------------------------------------------
module crfe_core import crfe_pkg::*; #(
  parameter int MAX_DIM   = MaxDimDefault,
  parameter int ADDR_BITS = AddrBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [CoordW-1:0] rect_x_i,
  input  logic [CoordW-1:0] rect_y_i,
  input  logic [DimW-1:0]   rect_width_i,
  input  logic [DimW-1:0]   rect_height_i,
  input  logic [ColorW-1:0] fill_red_i,
  input  logic [ColorW-1:0] fill_green_i,
  input  logic [ColorW-1:0] fill_blue_i,
  input  logic [ColorW-1:0] fill_alpha_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              res_o
);

  localparam int ExtW = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam int ProdW = CoordW + PitchW;
  localparam int OffW = CoordW + 2;

  // input register
  logic              in_vld_q;
  op_e               op_q;
  logic [CoordW-1:0] x_q, y_q;
  logic [DimW-1:0]   w_q, h_q;
  logic [ColorW-1:0] r_q, g_q, b_q, a_q;

  // fill state
  logic                 active_q;
  logic [CoordW-1:0]    cur_col_q, cur_row_q, start_col_q;
  logic [DimW-1:0]      col_lim_q, row_lim_q;
  logic [ADDR_BITS-1:0] row_addr_q;
  logic [DataW-1:0]     packed_q;

  // result register
  logic out_vld_q;
  res_t res_q;

  logic adv, is_step;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign is_step    = (op_q == OpStep);
  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

  // capture input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q <= op_e'(op_i);
      x_q  <= rect_x_i;
      y_q  <= rect_y_i;
      w_q  <= rect_width_i;
      h_q  <= rect_height_i;
      r_q  <= fill_red_i;
      g_q  <= fill_green_i;
      b_q  <= fill_blue_i;
      a_q  <= fill_alpha_i;
    end
  end

  // start: clip against screen, clamped to the maximum dimension
  logic [DimW-1:0]      eff_w, eff_h, x_end, y_end, new_col_lim, new_row_lim;
  logic [ProdW-1:0]     y_prod;
  logic [ADDR_BITS-1:0] new_row_addr;
  logic [DataW-1:0]     new_packed;
  logic                 new_active;

  always_comb begin
    eff_w = (32'(cfg_i.screen_width) > 32'(MAX_DIM)) ? DimW'(MAX_DIM) : cfg_i.screen_width;
    eff_h = (32'(cfg_i.screen_height) > 32'(MAX_DIM)) ? DimW'(MAX_DIM) : cfg_i.screen_height;
    x_end = DimW'(x_q) + w_q;
    y_end = DimW'(y_q) + h_q;
    new_col_lim = (x_end < eff_w) ? x_end : eff_w;
    new_row_lim = (y_end < eff_h) ? y_end : eff_h;
    new_active  = (DimW'(x_q) < new_col_lim) && (DimW'(y_q) < new_row_lim);
    y_prod       = ProdW'(y_q) * ProdW'(cfg_i.row_pitch);
    new_row_addr = ADDR_BITS'(cfg_i.base_address) + ADDR_BITS'(y_prod);
  end

  // colour packing by current format
  always_comb begin
    case (cfg_i.pixel_format)
      FmtBgra32: new_packed = {a_q, r_q, g_q, b_q};
      FmtBgr24:  new_packed = {8'h00, r_q, g_q, b_q};
      FmtRgb565: new_packed = {16'h0000, r_q[7:3], g_q[7:2], b_q[7:3]};
      default:   new_packed = '0;
    endcase
  end

  // step: pixel address and cursor advance
  logic [OffW-1:0]      col_off;
  logic [ADDR_BITS-1:0] pix_addr;
  logic [ExtW-1:0]      pix_addr_ext;
  logic [BeW-1:0]       be;
  logic                 last_col, last_row;
  res_t                 step_res;

  always_comb begin
    case (cfg_i.pixel_format)
      FmtBgra32: begin
        col_off = {cur_col_q, 2'b00};
        be      = 4'hF;
      end
      FmtBgr24: begin
        col_off = OffW'(cur_col_q) + {1'b0, cur_col_q, 1'b0};
        be      = 4'h7;
      end
      FmtRgb565: begin
        col_off = {1'b0, cur_col_q, 1'b0};
        be      = 4'h3;
      end
      default: begin
        col_off = '0;
        be      = 4'h0;
      end
    endcase
    pix_addr     = row_addr_q + ADDR_BITS'(col_off);
    pix_addr_ext = ExtW'(pix_addr);
    last_col     = (DimW'(cur_col_q) + DimW'(1)) >= col_lim_q;
    last_row     = (DimW'(cur_row_q) + DimW'(1)) >= row_lim_q;

    step_res = '0;
    if (active_q) begin
      step_res.write_valid   = 1'b1;
      step_res.write_address = pix_addr_ext[31:0];
      step_res.write_data    = (cfg_i.pixel_format == FmtOther) ? '0 : packed_q;
      step_res.byte_enables  = be;
      step_res.pixel_col     = cur_col_q;
      step_res.pixel_row     = cur_row_q;
      step_res.last_pixel    = last_col && last_row;
    end
  end

  // fill state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      start_col_q <= '0;
      col_lim_q   <= '0;
      row_lim_q   <= '0;
      row_addr_q  <= '0;
      packed_q    <= '0;
    end else if (adv) begin
      if (!is_step) begin
        active_q    <= new_active;
        cur_col_q   <= x_q;
        cur_row_q   <= y_q;
        start_col_q <= x_q;
        col_lim_q   <= new_col_lim;
        row_lim_q   <= new_row_lim;
        row_addr_q  <= new_row_addr;
        packed_q    <= new_packed;
      end else if (active_q) begin
        if (!last_col) begin
          cur_col_q <= cur_col_q + CoordW'(1);
        end else if (!last_row) begin
          cur_col_q  <= start_col_q;
          cur_row_q  <= cur_row_q + CoordW'(1);
          row_addr_q <= row_addr_q + ADDR_BITS'(cfg_i.row_pitch);
        end else begin
          active_q <= 1'b0;
        end
      end
    end
  end

  // result register, held while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && is_step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && is_step) begin
      res_q <= step_res;
    end
  end

endmodule

@@ sv/clipped_rect_fill_engine.sv @@
// Path: an item is registered in the input register on transfer and its result
//   in the result register; a start item produces no result.
// Throughput: one item per cycle unless the result stalls, set by the state
//   update in the fill datapath between the input and result registers.
// Reset: rst_ni is asynchronous and active low; it clears configuration,
//   fill state and all valid flags.
// ----------------------------------------------------------------------------
// clipped_rect_fill_engine
// Fill engine: a start item latches a clipped rectangle and packed colour, each
// step item of an active fill issues one framebuffer pixel write, row-major.
// ----------------------------------------------------------------------------
module clipped_rect_fill_engine import crfe_pkg::*; #(
  parameter int MAX_DIM   = MaxDimDefault,
  parameter int ADDR_BITS = AddrBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [CoordW-1:0] rect_x_i,
  input  logic [CoordW-1:0] rect_y_i,
  input  logic [DimW-1:0]   rect_width_i,
  input  logic [DimW-1:0]   rect_height_i,
  input  logic [ColorW-1:0] fill_red_i,
  input  logic [ColorW-1:0] fill_green_i,
  input  logic [ColorW-1:0] fill_blue_i,
  input  logic [ColorW-1:0] fill_alpha_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              write_valid_o,
  output logic [31:0]       write_address_o,
  output logic [DataW-1:0]  write_data_o,
  output logic [BeW-1:0]    byte_enables_o,
  output logic [CoordW-1:0] pixel_col_o,
  output logic [CoordW-1:0] pixel_row_o,
  output logic              last_pixel_o
);

  cfg_t cfg;
  res_t res;

  // configuration registers
  crfe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // fill datapath
  crfe_core #(
    .MAX_DIM   (MAX_DIM),
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .rect_x_i      (rect_x_i),
    .rect_y_i      (rect_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .fill_red_i    (fill_red_i),
    .fill_green_i  (fill_green_i),
    .fill_blue_i   (fill_blue_i),
    .fill_alpha_i  (fill_alpha_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .res_o         (res)
  );

  // result fields
  assign write_valid_o   = res.write_valid;
  assign write_address_o = res.write_address;
  assign write_data_o    = res.write_data;
  assign byte_enables_o  = res.byte_enables;
  assign pixel_col_o     = res.pixel_col;
  assign pixel_row_o     = res.pixel_row;
  assign last_pixel_o    = res.last_pixel;

endmodule

@@ sv/crfe_checker.sv @@
// ----------------------------------------------------------------------------
// crfe_checker
// Port-level checks of the fill engine: result hold on stall, idle results
// and byte enable codes. Bound to the top level.
// ----------------------------------------------------------------------------
module crfe_checker import crfe_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              write_valid_o,
  input logic [31:0]       write_address_o,
  input logic [DataW-1:0]  write_data_o,
  input logic [BeW-1:0]    byte_enables_o,
  input logic              last_pixel_o
);

  // stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result keeps its address
  a_hold_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(write_address_o))
    else $error("result address changed while stalled");

  // step without an active fill gives an all-zero write
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |->
      write_address_o == '0 && write_data_o == '0 && byte_enables_o == '0 && !last_pixel_o)
    else $error("idle step result not zero");

  // byte enables follow one of the format codes, no data without enables
  a_be_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |->
      (byte_enables_o == 4'hF || byte_enables_o == 4'h7 ||
       byte_enables_o == 4'h3 || (byte_enables_o == 4'h0 && write_data_o == '0)))
    else $error("bad byte enable pattern");

endmodule

bind clipped_rect_fill_engine crfe_checker u_crfe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .write_valid_o   (write_valid_o),
  .write_address_o (write_address_o),
  .write_data_o    (write_data_o),
  .byte_enables_o  (byte_enables_o),
  .last_pixel_o    (last_pixel_o)
);
